@@ rtl/kpq_pkg.sv @@
package kpq_pkg;

    typedef enum logic [2:0] {
        CMD_KEY_DOWN     = 3'd0,
        CMD_TEXT_BYTE    = 3'd1,
        CMD_MOVE         = 3'd2,
        CMD_BUTTON_DOWN  = 3'd3,
        CMD_BUTTON_UP    = 3'd4,
        CMD_READ_KEY     = 3'd5,
        CMD_READ_POINTER = 3'd6,
        CMD_RESERVED     = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        RES_EMPTY = 2'd0,
        RES_KEY   = 2'd1,
        RES_EDGE  = 2'd2,
        RES_CUR   = 2'd3
    } res_kind_t;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [2:0]  buttons;
    } edge_t;

    localparam logic [2:0] SPECIAL_NONE     = 3'd0;
    localparam logic [2:0] SPECIAL_UP       = 3'd1;
    localparam logic [2:0] SPECIAL_LEFT     = 3'd4;
    localparam logic [2:0] SPECIAL_KP_ENTER = 3'd5;

    localparam logic [7:0] CHAR_ESC      = 8'h1b;
    localparam logic [7:0] CHAR_DEL      = 8'h7f;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5b;
    localparam logic [7:0] CHAR_CR       = 8'h0d;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_BS       = 8'h08;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7a;
    localparam logic [7:0] CTRL_OFFSET   = 8'h60;
    localparam logic [7:0] ARROW_BASE    = 8'h40;

    localparam logic       CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic       CFG_SCREEN_HEIGHT = 1'b1;
    localparam logic [12:0] SCREEN_MAX       = 13'd4096;
    localparam logic [12:0] WIDTH_RESET      = 13'd1024;
    localparam logic [12:0] HEIGHT_RESET     = 13'd768;

    localparam logic [1:0] ARROW_LAST_STEP = 2'd2;

    function automatic logic [11:0] clamp_axis(input logic signed [15:0] v,
                                               input logic [12:0] limit);
        logic [12:0] lim;
        logic [12:0] lim_m1;
        logic [11:0] res;
        lim = limit;
        if (limit == 13'd0)
        begin
            lim = 13'd1;
        end
        else if (limit > SCREEN_MAX)
        begin
            lim = SCREEN_MAX;
        end
        lim_m1 = lim - 13'd1;
        if (v < 16'sd0)
        begin
            res = 12'd0;
        end
        else if ($unsigned(v) >= {3'b000, lim})
        begin
            res = lim_m1[11:0];
        end
        else
        begin
            res = v[11:0];
        end
        return res;
    endfunction

    function automatic logic [2:0] button_mask(input logic [2:0] num);
        logic [2:0] m;
        case (num)
            3'd1:    m = 3'b001;
            3'd2:    m = 3'b010;
            3'd3:    m = 3'b100;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/keyboard_pointer_event_queue_core.sv @@
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  command, key_code, key_special, ctrl_held,
//                                           text_byte, pos_x, pos_y, button_number
// result    out        out_valid/out_stall  key_valid, key_byte, ptr_valid, ptr_x,
//                                           ptr_y, ptr_buttons
// config    in         cfg_wr_en            cfg_index, cfg_data
//
// one transaction per cycle when not stalled; an arrow key holds the input register
// until all its bytes are pushed, as the key ring memory has a single write port
// (one byte per cycle); read results pass the input reg, memory read and output reg
// rst_n clears pointers, pointer state and pipeline valids; the rings need no clearing
// out_stall holds the output register; reads back up and hold all later commands
module keyboard_pointer_event_queue_core #(
    parameter int KEY_DEPTH  = 256,
    parameter int EDGE_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [7:0]         key_code,
    input  logic [2:0]         key_special,
    input  logic               ctrl_held,
    input  logic [7:0]         text_byte,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [2:0]         button_number,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               key_valid,
    output logic [7:0]         key_byte,
    output logic               ptr_valid,
    output logic [11:0]        ptr_x,
    output logic [11:0]        ptr_y,
    output logic [2:0]         ptr_buttons,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_data
);

    localparam int KEY_AW  = $clog2(KEY_DEPTH);
    localparam int EDGE_AW = $clog2(EDGE_DEPTH);
    localparam int EDGE_W  = $bits(kpq_pkg::edge_t);

    // config
    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;

    // input register
    logic               r0_valid_reg, r0_valid_next;
    logic [2:0]         r0_command_reg;
    logic [7:0]         r0_key_code_reg;
    logic [2:0]         r0_key_special_reg;
    logic               r0_ctrl_reg;
    logic [7:0]         r0_text_reg;
    logic signed [15:0] r0_pos_x_reg;
    logic signed [15:0] r0_pos_y_reg;
    logic [2:0]         r0_button_reg;
    logic [1:0]         arrow_step_reg, arrow_step_next;
    kpq_pkg::cmd_t      r0_cmd;

    // ring pointers and pointer state
    logic [KEY_AW-1:0]  key_head_reg, key_head_next;
    logic [KEY_AW-1:0]  key_tail_reg, key_tail_next;
    logic [EDGE_AW-1:0] edge_head_reg, edge_head_next;
    logic [EDGE_AW-1:0] edge_tail_reg, edge_tail_next;
    logic [11:0]        cur_x_reg, cur_x_next;
    logic [11:0]        cur_y_reg, cur_y_next;
    logic [2:0]         cur_buttons_reg, cur_buttons_next;
    logic               move_pending_reg, move_pending_next;

    // read stage
    logic                 r1_valid_reg, r1_valid_next;
    kpq_pkg::res_kind_t   r1_kind_reg, r1_kind_next;
    kpq_pkg::edge_t       r1_cur_reg, r1_cur_next;

    // output register
    logic        ov_valid_reg;
    logic        key_valid_reg, key_valid_next;
    logic [7:0]  key_byte_reg, key_byte_next;
    logic        ptr_valid_reg, ptr_valid_next;
    logic [11:0] ptr_x_reg, ptr_x_next;
    logic [11:0] ptr_y_reg, ptr_y_next;
    logic [2:0]  ptr_buttons_reg, ptr_buttons_next;

    // control
    logic ov_load_ok;
    logic r1_free;
    logic is_read;
    logic is_arrow;
    logic r0_active;
    logic r0_fire;
    logic in_accept;

    // key push decode
    logic       push_req;
    logic [7:0] push_byte;

    logic [KEY_AW-1:0]  key_tail_inc, key_head_inc;
    logic [EDGE_AW-1:0] edge_tail_inc, edge_tail_dec, edge_head_inc;

    logic [11:0] clamp_x, clamp_y;
    logic [2:0]  btn_mask;

    // memory ports
    logic               key_we, key_re;
    logic [7:0]         key_rdata;
    logic               edge_we, edge_re;
    logic [EDGE_AW-1:0] edge_waddr;
    kpq_pkg::edge_t     edge_wdata;
    logic [EDGE_W-1:0]  edge_rdata_raw;
    kpq_pkg::edge_t     edge_rdata;

    assign r0_cmd = kpq_pkg::cmd_t'(r0_command_reg);

    assign ov_load_ok = !ov_valid_reg || !out_stall;
    assign r1_free    = !r1_valid_reg || ov_load_ok;
    assign is_read    = (r0_cmd == kpq_pkg::CMD_READ_KEY) ||
                        (r0_cmd == kpq_pkg::CMD_READ_POINTER);
    assign is_arrow   = (r0_cmd == kpq_pkg::CMD_KEY_DOWN) && !r0_ctrl_reg &&
                        (r0_key_special_reg >= kpq_pkg::SPECIAL_UP) &&
                        (r0_key_special_reg <= kpq_pkg::SPECIAL_LEFT);
    assign r0_active  = r0_valid_reg && (!is_read || r1_free);
    assign r0_fire    = r0_active && (!is_arrow || arrow_step_reg == kpq_pkg::ARROW_LAST_STEP);
    assign in_stall   = r0_valid_reg && !r0_fire;
    assign in_accept  = in_valid && !in_stall;

    assign key_tail_inc  = (key_tail_reg == KEY_AW'(KEY_DEPTH - 1)) ? '0 :
                           key_tail_reg + KEY_AW'(1);
    assign key_head_inc  = (key_head_reg == KEY_AW'(KEY_DEPTH - 1)) ? '0 :
                           key_head_reg + KEY_AW'(1);
    assign edge_tail_inc = (edge_tail_reg == EDGE_AW'(EDGE_DEPTH - 1)) ? '0 :
                           edge_tail_reg + EDGE_AW'(1);
    assign edge_tail_dec = (edge_tail_reg == '0) ? EDGE_AW'(EDGE_DEPTH - 1) :
                           edge_tail_reg - EDGE_AW'(1);
    assign edge_head_inc = (edge_head_reg == EDGE_AW'(EDGE_DEPTH - 1)) ? '0 :
                           edge_head_reg + EDGE_AW'(1);

    assign clamp_x  = kpq_pkg::clamp_axis(r0_pos_x_reg, screen_width_reg);
    assign clamp_y  = kpq_pkg::clamp_axis(r0_pos_y_reg, screen_height_reg);
    assign btn_mask = kpq_pkg::button_mask(r0_button_reg);

    // byte to push for key_down and text_byte
    always_comb
    begin
        push_req  = 1'b0;
        push_byte = 8'd0;
        case (r0_cmd)
            kpq_pkg::CMD_KEY_DOWN:
            begin
                if (r0_ctrl_reg)
                begin
                    if (r0_key_special_reg == kpq_pkg::SPECIAL_NONE &&
                        r0_key_code_reg >= kpq_pkg::CHAR_LOWER_A &&
                        r0_key_code_reg <= kpq_pkg::CHAR_LOWER_Z)
                    begin
                        push_req  = 1'b1;
                        push_byte = r0_key_code_reg - kpq_pkg::CTRL_OFFSET;
                    end
                end
                else if (is_arrow)
                begin
                    push_req = 1'b1;
                    case (arrow_step_reg)
                        2'd0:    push_byte = kpq_pkg::CHAR_ESC;
                        2'd1:    push_byte = kpq_pkg::CHAR_LBRACKET;
                        default: push_byte = kpq_pkg::ARROW_BASE + {5'd0, r0_key_special_reg};
                    endcase
                end
                else if (r0_key_special_reg == kpq_pkg::SPECIAL_KP_ENTER)
                begin
                    push_req  = 1'b1;
                    push_byte = kpq_pkg::CHAR_CR;
                end
                else if (r0_key_special_reg == kpq_pkg::SPECIAL_NONE)
                begin
                    case (r0_key_code_reg)
                        kpq_pkg::CHAR_CR:
                        begin
                            push_req  = 1'b1;
                            push_byte = kpq_pkg::CHAR_CR;
                        end
                        kpq_pkg::CHAR_BS:
                        begin
                            push_req  = 1'b1;
                            push_byte = kpq_pkg::CHAR_DEL;
                        end
                        kpq_pkg::CHAR_ESC:
                        begin
                            push_req  = 1'b1;
                            push_byte = kpq_pkg::CHAR_ESC;
                        end
                        kpq_pkg::CHAR_TAB:
                        begin
                            push_req  = 1'b1;
                            push_byte = kpq_pkg::CHAR_TAB;
                        end
                        default:
                        begin
                            push_req = 1'b0;
                        end
                    endcase
                end
            end
            kpq_pkg::CMD_TEXT_BYTE:
            begin
                push_req  = (r0_text_reg != 8'd0);
                push_byte = r0_text_reg;
            end
            default:
            begin
                push_req = 1'b0;
            end
        endcase
    end

    // per-transaction state update
    always_comb
    begin
        key_head_next     = key_head_reg;
        key_tail_next     = key_tail_reg;
        edge_head_next    = edge_head_reg;
        edge_tail_next    = edge_tail_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        cur_buttons_next  = cur_buttons_reg;
        move_pending_next = move_pending_reg;
        arrow_step_next   = arrow_step_reg;
        key_we            = 1'b0;
        key_re            = 1'b0;
        edge_we           = 1'b0;
        edge_re           = 1'b0;
        edge_waddr        = edge_tail_reg;
        r1_kind_next      = r1_kind_reg;
        r1_cur_next       = r1_cur_reg;

        if (r0_active && is_arrow)
        begin
            arrow_step_next = (arrow_step_reg == kpq_pkg::ARROW_LAST_STEP) ? 2'd0 :
                              arrow_step_reg + 2'd1;
        end

        // ring full drops the byte
        if (r0_active && push_req && key_tail_inc != key_head_reg)
        begin
            key_we        = 1'b1;
            key_tail_next = key_tail_inc;
        end

        if (r0_fire)
        begin
            case (r0_cmd)
                kpq_pkg::CMD_MOVE:
                begin
                    cur_x_next        = clamp_x;
                    cur_y_next        = clamp_y;
                    move_pending_next = 1'b1;
                end
                kpq_pkg::CMD_BUTTON_DOWN, kpq_pkg::CMD_BUTTON_UP:
                begin
                    cur_x_next = clamp_x;
                    cur_y_next = clamp_y;
                    if (r0_cmd == kpq_pkg::CMD_BUTTON_DOWN)
                    begin
                        cur_buttons_next = cur_buttons_reg | btn_mask;
                    end
                    else
                    begin
                        cur_buttons_next = cur_buttons_reg & ~btn_mask;
                    end
                    edge_we = 1'b1;
                    // full ring: overwrite the newest edge, tail stays
                    if (edge_tail_inc == edge_head_reg)
                    begin
                        edge_waddr = edge_tail_dec;
                    end
                    else
                    begin
                        edge_tail_next = edge_tail_inc;
                    end
                end
                kpq_pkg::CMD_READ_KEY:
                begin
                    if (key_head_reg != key_tail_reg)
                    begin
                        key_re        = 1'b1;
                        key_head_next = key_head_inc;
                        r1_kind_next  = kpq_pkg::RES_KEY;
                    end
                    else
                    begin
                        r1_kind_next = kpq_pkg::RES_EMPTY;
                    end
                end
                kpq_pkg::CMD_READ_POINTER:
                begin
                    if (edge_head_reg != edge_tail_reg)
                    begin
                        edge_re        = 1'b1;
                        edge_head_next = edge_head_inc;
                        r1_kind_next   = kpq_pkg::RES_EDGE;
                    end
                    else if (move_pending_reg)
                    begin
                        move_pending_next   = 1'b0;
                        r1_kind_next        = kpq_pkg::RES_CUR;
                        r1_cur_next.x       = cur_x_reg;
                        r1_cur_next.y       = cur_y_reg;
                        r1_cur_next.buttons = cur_buttons_reg;
                    end
                    else
                    begin
                        r1_kind_next = kpq_pkg::RES_EMPTY;
                    end
                end
                default:
                begin
                    move_pending_next = move_pending_reg;
                end
            endcase
        end
    end

    assign edge_wdata.x       = cur_x_next;
    assign edge_wdata.y       = cur_y_next;
    assign edge_wdata.buttons = cur_buttons_next;
    assign edge_rdata         = kpq_pkg::edge_t'(edge_rdata_raw);

    always_comb
    begin
        if (r0_fire && is_read)
        begin
            r1_valid_next = 1'b1;
        end
        else if (ov_load_ok)
        begin
            r1_valid_next = 1'b0;
        end
        else
        begin
            r1_valid_next = r1_valid_reg;
        end
    end

    always_comb
    begin
        if (in_accept)
        begin
            r0_valid_next = 1'b1;
        end
        else if (r0_fire)
        begin
            r0_valid_next = 1'b0;
        end
        else
        begin
            r0_valid_next = r0_valid_reg;
        end
    end

    // result fields from the read stage
    always_comb
    begin
        key_valid_next   = 1'b0;
        key_byte_next    = 8'd0;
        ptr_valid_next   = 1'b0;
        ptr_x_next       = 12'd0;
        ptr_y_next       = 12'd0;
        ptr_buttons_next = 3'd0;
        case (r1_kind_reg)
            kpq_pkg::RES_KEY:
            begin
                key_valid_next = 1'b1;
                key_byte_next  = key_rdata;
            end
            kpq_pkg::RES_EDGE:
            begin
                ptr_valid_next   = 1'b1;
                ptr_x_next       = edge_rdata.x;
                ptr_y_next       = edge_rdata.y;
                ptr_buttons_next = edge_rdata.buttons;
            end
            kpq_pkg::RES_CUR:
            begin
                ptr_valid_next   = 1'b1;
                ptr_x_next       = r1_cur_reg.x;
                ptr_y_next       = r1_cur_reg.y;
                ptr_buttons_next = r1_cur_reg.buttons;
            end
            default:
            begin
                key_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= kpq_pkg::WIDTH_RESET;
            screen_height_reg <= kpq_pkg::HEIGHT_RESET;
            r0_valid_reg      <= 1'b0;
            arrow_step_reg    <= 2'd0;
            key_head_reg      <= '0;
            key_tail_reg      <= '0;
            edge_head_reg     <= '0;
            edge_tail_reg     <= '0;
            cur_x_reg         <= 12'd0;
            cur_y_reg         <= 12'd0;
            cur_buttons_reg   <= 3'd0;
            move_pending_reg  <= 1'b0;
            r1_valid_reg      <= 1'b0;
            ov_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index == kpq_pkg::CFG_SCREEN_WIDTH)
            begin
                screen_width_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == kpq_pkg::CFG_SCREEN_HEIGHT)
            begin
                screen_height_reg <= cfg_data;
            end
            r0_valid_reg     <= r0_valid_next;
            arrow_step_reg   <= arrow_step_next;
            key_head_reg     <= key_head_next;
            key_tail_reg     <= key_tail_next;
            edge_head_reg    <= edge_head_next;
            edge_tail_reg    <= edge_tail_next;
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            cur_buttons_reg  <= cur_buttons_next;
            move_pending_reg <= move_pending_next;
            r1_valid_reg     <= r1_valid_next;
            if (ov_load_ok)
            begin
                ov_valid_reg <= r1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            r0_command_reg     <= command;
            r0_key_code_reg    <= key_code;
            r0_key_special_reg <= key_special;
            r0_ctrl_reg        <= ctrl_held;
            r0_text_reg        <= text_byte;
            r0_pos_x_reg       <= pos_x;
            r0_pos_y_reg       <= pos_y;
            r0_button_reg      <= button_number;
        end
        if (r0_fire && is_read)
        begin
            r1_kind_reg <= r1_kind_next;
            r1_cur_reg  <= r1_cur_next;
        end
        if (ov_load_ok)
        begin
            key_valid_reg   <= key_valid_next;
            key_byte_reg    <= key_byte_next;
            ptr_valid_reg   <= ptr_valid_next;
            ptr_x_reg       <= ptr_x_next;
            ptr_y_reg       <= ptr_y_next;
            ptr_buttons_reg <= ptr_buttons_next;
        end
    end

    kpq_ram #(
        .WIDTH (8),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_tail_reg),
        .wdata (push_byte),
        .re    (key_re),
        .raddr (key_head_reg),
        .rdata (key_rdata)
    );

    kpq_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_head_reg),
        .rdata (edge_rdata_raw)
    );

    assign out_valid   = ov_valid_reg;
    assign key_valid   = key_valid_reg;
    assign key_byte    = key_byte_reg;
    assign ptr_valid   = ptr_valid_reg;
    assign ptr_x       = ptr_x_reg;
    assign ptr_y       = ptr_y_reg;
    assign ptr_buttons = ptr_buttons_reg;

    a_read_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (r0_fire && is_read) |=> r1_valid_reg)
        else $error("read transaction did not reach the read stage");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(key_valid && ptr_valid))
        else $error("key and pointer result both valid");

    a_edge_ring_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        edge_we |=> (edge_head_reg != edge_tail_reg))
        else $error("edge ring empty after a push");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !r0_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

endmodule

@@ rtl/kpq_ram.sv @@
module kpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ dv/keyboard_pointer_event_queue_core_tb.sv @@
`timescale 1ns / 1ps

module keyboard_pointer_event_queue_core_tb;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [2:0] SPECIAL_UNKNOWN_LO = 3'd6;
    localparam logic [2:0] SPECIAL_UNKNOWN_HI = 3'd7;
    localparam logic [2:0] BTN_OTHER  = 3'd0;
    localparam logic [2:0] BTN_LEFT   = 3'd1;
    localparam logic [2:0] BTN_MIDDLE = 3'd2;
    localparam logic [2:0] BTN_RIGHT  = 3'd3;

    typedef struct {
        kpq_pkg::cmd_t      command;
        logic [7:0]         key_code;
        logic [2:0]         key_special;
        logic               ctrl_held;
        logic [7:0]         text_byte;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [2:0]         button_number;
    } console_req_t;

    typedef struct packed {
        logic        key_valid;
        logic [7:0]  key_byte;
        logic        ptr_valid;
        logic [11:0] ptr_x;
        logic [11:0] ptr_y;
        logic [2:0]  ptr_buttons;
    } read_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         command = '0;
    logic [7:0]         key_code = '0;
    logic [2:0]         key_special = '0;
    logic               ctrl_held = 1'b0;
    logic [7:0]         text_byte = '0;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic [2:0]         button_number = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               key_valid;
    logic [7:0]         key_byte;
    logic               ptr_valid;
    logic [11:0]        ptr_x;
    logic [11:0]        ptr_y;
    logic [2:0]         ptr_buttons;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = 1'b0;
    logic [12:0]        cfg_data = '0;

    keyboard_pointer_event_queue_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .key_code      (key_code),
        .key_special   (key_special),
        .ctrl_held     (ctrl_held),
        .text_byte     (text_byte),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .button_number (button_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .key_valid     (key_valid),
        .key_byte      (key_byte),
        .ptr_valid     (ptr_valid),
        .ptr_x         (ptr_x),
        .ptr_y         (ptr_y),
        .ptr_buttons   (ptr_buttons),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tracked console state
    logic [7:0]     kb_mem [0:255];
    logic [7:0]     kb_rd = '0;
    logic [7:0]     kb_wr = '0;
    kpq_pkg::edge_t ev_mem [0:31];
    logic [4:0]     ev_rd = '0;
    logic [4:0]     ev_wr = '0;
    logic [11:0]    px = '0;
    logic [11:0]    py = '0;
    logic [2:0]     pbtn = '0;
    logic           pmove = 1'b0;
    logic [12:0]    scr_w = kpq_pkg::WIDTH_RESET;
    logic [12:0]    scr_h = kpq_pkg::HEIGHT_RESET;

    console_req_t pending[$];
    read_res_t    reads_due[$];
    console_req_t cur_req;

    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_left = 0;
    bit  hold_ask = 1'b0;
    bit  hold_seen = 1'b0;
    bit  idle_on = 1'b1;
    int  quiet_cycles = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_bad = 0;
    int  n_settings = 0;

    function automatic logic [11:0] fit_axis(input logic signed [15:0] v,
                                             input logic [12:0] lim_in);
        int iv;
        int lim;
        iv = v;
        lim = lim_in;
        if (lim == 0)
        begin
            lim = 1;
        end
        else if (lim > 4096)
        begin
            lim = 4096;
        end
        if (iv < 0)
        begin
            return 12'd0;
        end
        if (iv >= lim)
        begin
            return 12'(lim - 1);
        end
        return v[11:0];
    endfunction

    function automatic logic [2:0] btn_bit(input logic [2:0] n);
        case (n)
            BTN_LEFT:   return 3'b001;
            BTN_MIDDLE: return 3'b010;
            BTN_RIGHT:  return 3'b100;
            default:    return 3'b000;
        endcase
    endfunction

    // full ring drops the byte
    function void kb_push(input logic [7:0] b);
        logic [7:0] nx;
        nx = kb_wr + 8'd1;
        if (nx != kb_rd)
        begin
            kb_mem[kb_wr] = b;
            kb_wr = nx;
        end
    endfunction

    // full ring replaces its newest entry
    function void ev_push();
        logic [4:0] nx;
        nx = ev_wr + 5'd1;
        if (nx == ev_rd)
        begin
            ev_wr = ev_wr - 5'd1;
        end
        ev_mem[ev_wr] = {px, py, pbtn};
        ev_wr = ev_wr + 5'd1;
    endfunction

    function void key_press(input logic [7:0] code, input logic [2:0] sp, input logic ctrl);
        if (ctrl)
        begin
            if (sp == kpq_pkg::SPECIAL_NONE && code >= kpq_pkg::CHAR_LOWER_A &&
                code <= kpq_pkg::CHAR_LOWER_Z)
            begin
                kb_push(code - kpq_pkg::CTRL_OFFSET);
            end
        end
        else if (sp >= kpq_pkg::SPECIAL_UP && sp <= kpq_pkg::SPECIAL_LEFT)
        begin
            kb_push(kpq_pkg::CHAR_ESC);
            kb_push(kpq_pkg::CHAR_LBRACKET);
            kb_push(kpq_pkg::ARROW_BASE + {5'd0, sp});
        end
        else if (sp == kpq_pkg::SPECIAL_KP_ENTER)
        begin
            kb_push(kpq_pkg::CHAR_CR);
        end
        else if (sp == kpq_pkg::SPECIAL_NONE)
        begin
            case (code)
                kpq_pkg::CHAR_CR:  kb_push(kpq_pkg::CHAR_CR);
                kpq_pkg::CHAR_BS:  kb_push(kpq_pkg::CHAR_DEL);
                kpq_pkg::CHAR_ESC: kb_push(kpq_pkg::CHAR_ESC);
                kpq_pkg::CHAR_TAB: kb_push(kpq_pkg::CHAR_TAB);
                default:  ;
            endcase
        end
    endfunction

    function void track_console(input console_req_t r);
        read_res_t      res;
        kpq_pkg::edge_t e;
        res = '0;
        case (r.command)
            kpq_pkg::CMD_KEY_DOWN:
                key_press(r.key_code, r.key_special, r.ctrl_held);
            kpq_pkg::CMD_TEXT_BYTE:
                if (r.text_byte != 8'd0)
                begin
                    kb_push(r.text_byte);
                end
            kpq_pkg::CMD_MOVE:
            begin
                px = fit_axis(r.pos_x, scr_w);
                py = fit_axis(r.pos_y, scr_h);
                pmove = 1'b1;
            end
            kpq_pkg::CMD_BUTTON_DOWN, kpq_pkg::CMD_BUTTON_UP:
            begin
                px = fit_axis(r.pos_x, scr_w);
                py = fit_axis(r.pos_y, scr_h);
                if (r.command == kpq_pkg::CMD_BUTTON_DOWN)
                begin
                    pbtn = pbtn | btn_bit(r.button_number);
                end
                else
                begin
                    pbtn = pbtn & ~btn_bit(r.button_number);
                end
                ev_push();
            end
            kpq_pkg::CMD_READ_KEY:
            begin
                if (kb_rd != kb_wr)
                begin
                    res.key_valid = 1'b1;
                    res.key_byte = kb_mem[kb_rd];
                    kb_rd = kb_rd + 8'd1;
                end
                reads_due.push_back(res);
            end
            kpq_pkg::CMD_READ_POINTER:
            begin
                if (ev_rd != ev_wr)
                begin
                    e = ev_mem[ev_rd];
                    res.ptr_valid = 1'b1;
                    res.ptr_x = e.x;
                    res.ptr_y = e.y;
                    res.ptr_buttons = e.buttons;
                    ev_rd = ev_rd + 5'd1;
                end
                else if (pmove)
                begin
                    pmove = 1'b0;
                    res.ptr_valid = 1'b1;
                    res.ptr_x = px;
                    res.ptr_y = py;
                    res.ptr_buttons = pbtn;
                end
                reads_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // every field random, so ignored fields toggle too
    function automatic console_req_t any_req(input kpq_pkg::cmd_t c);
        console_req_t r;
        r.command = c;
        r.key_code = 8'($urandom);
        r.key_special = 3'($urandom);
        r.ctrl_held = 1'($urandom);
        r.text_byte = 8'($urandom);
        r.pos_x = 16'($urandom);
        r.pos_y = 16'($urandom);
        r.button_number = 3'($urandom);
        return r;
    endfunction

    function automatic logic signed [15:0] rand_axis(input logic [12:0] lim);
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0:       v = 16'($urandom);
            1:       v = 16'(lim + $urandom_range(0, 2) - 1);
            default: v = 16'($urandom_range(0, lim));
        endcase
        return $signed(v);
    endfunction

    function automatic console_req_t rand_key();
        console_req_t r;
        r = any_req(kpq_pkg::CMD_KEY_DOWN);
        case ($urandom_range(0, 3))
            0:
            begin
                r.key_special = 3'($urandom_range(1, 5));
                r.ctrl_held = ($urandom_range(0, 5) == 0);
            end
            1:
            begin
                r.key_special = kpq_pkg::SPECIAL_NONE;
                r.ctrl_held = ($urandom_range(0, 5) == 0);
                case ($urandom_range(0, 3))
                    0:       r.key_code = kpq_pkg::CHAR_CR;
                    1:       r.key_code = kpq_pkg::CHAR_BS;
                    2:       r.key_code = kpq_pkg::CHAR_ESC;
                    default: r.key_code = kpq_pkg::CHAR_TAB;
                endcase
            end
            2:
            begin
                r.key_special = kpq_pkg::SPECIAL_NONE;
                r.ctrl_held = 1'b1;
                r.key_code = 8'($urandom_range(kpq_pkg::CHAR_LOWER_A - 8'd1,
                                               kpq_pkg::CHAR_LOWER_Z + 8'd1));
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic console_req_t rand_pointer(input kpq_pkg::cmd_t c);
        console_req_t r;
        r = any_req(c);
        r.pos_x = rand_axis(scr_w);
        r.pos_y = rand_axis(scr_h);
        if ($urandom_range(0, 4) != 0)
        begin
            r.button_number = 3'($urandom_range(BTN_LEFT, BTN_RIGHT));
        end
        return r;
    endfunction

    task automatic queue_mix(input int n, input int wk, input int wt, input int wm,
                             input int wb, input int wr, input int wp, input int wn);
        int total;
        int pick;
        console_req_t r;
        total = wk + wt + wm + wb + wr + wp + wn;
        repeat (n)
        begin
            pick = $urandom_range(0, total - 1);
            if (pick < wk)
            begin
                r = rand_key();
            end
            else if (pick < wk + wt)
            begin
                r = any_req(kpq_pkg::CMD_TEXT_BYTE);
                if ($urandom_range(0, 15) == 0)
                begin
                    r.text_byte = 8'd0;
                end
            end
            else if (pick < wk + wt + wm)
            begin
                r = rand_pointer(kpq_pkg::CMD_MOVE);
            end
            else if (pick < wk + wt + wm + wb)
            begin
                r = rand_pointer($urandom_range(0, 1) ? kpq_pkg::CMD_BUTTON_DOWN :
                                                        kpq_pkg::CMD_BUTTON_UP);
            end
            else if (pick < wk + wt + wm + wb + wr)
            begin
                r = any_req(kpq_pkg::CMD_READ_KEY);
            end
            else if (pick < wk + wt + wm + wb + wr + wp)
            begin
                r = any_req(kpq_pkg::CMD_READ_POINTER);
            end
            else
            begin
                r = any_req(kpq_pkg::cmd_t'(3'($urandom_range(0, 7))));
            end
            pending.push_back(r);
        end
    endtask

    task automatic push_key(input logic [7:0] code, input logic [2:0] sp, input logic ctrl);
        console_req_t r;
        r = any_req(kpq_pkg::CMD_KEY_DOWN);
        r.key_code = code;
        r.key_special = sp;
        r.ctrl_held = ctrl;
        pending.push_back(r);
    endtask

    task automatic push_text(input logic [7:0] b);
        console_req_t r;
        r = any_req(kpq_pkg::CMD_TEXT_BYTE);
        r.text_byte = b;
        pending.push_back(r);
    endtask

    task automatic push_ptr(input kpq_pkg::cmd_t c, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic [2:0] btn);
        console_req_t r;
        r = any_req(c);
        r.pos_x = x;
        r.pos_y = y;
        r.button_number = btn;
        pending.push_back(r);
    endtask

    task automatic push_plain(input kpq_pkg::cmd_t c);
        pending.push_back(any_req(c));
    endtask

    // checked at the falling edge so the driver's updates have settled
    task automatic wait_quiet();
        while (pending.size() > 0 || in_valid || reads_due.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_screen(input logic [12:0] w, input logic [12:0] h);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= kpq_pkg::CFG_SCREEN_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        scr_w = w;
        cfg_index <= kpq_pkg::CFG_SCREEN_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        scr_h = h;
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_console(cur_req);
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    cur_req = pending.pop_front();
                    command <= cur_req.command;
                    key_code <= cur_req.key_code;
                    key_special <= cur_req.key_special;
                    ctrl_held <= cur_req.ctrl_held;
                    text_byte <= cur_req.text_byte;
                    pos_x <= cur_req.pos_x;
                    pos_y <= cur_req.pos_y;
                    button_number <= cur_req.button_number;
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                    begin
                        tx_gap = $urandom_range(1, 9);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_seen != hold_ask)
        begin
            hold_seen <= hold_ask;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rx_gap = $urandom_range(0, 8);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // result check
    always @(posedge clk)
    begin
        read_res_t got;
        read_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {key_valid, key_byte, ptr_valid, ptr_x, ptr_y, ptr_buttons};
            if (reads_due.size() == 0)
            begin
                if (n_bad < MAX_REPORTS)
                begin
                    $display("unexpected result: key %0b %02h ptr %0b %0d %0d %03b",
                             got.key_valid, got.key_byte, got.ptr_valid,
                             got.ptr_x, got.ptr_y, got.ptr_buttons);
                end
                n_bad++;
            end
            else
            begin
                want = reads_due.pop_front();
                n_checked++;
                if (got !== want)
                begin
                    if (n_bad < MAX_REPORTS)
                    begin
                        $display({"mismatch at result %0d: expected key %0b %02h ",
                                  "ptr %0b %0d %0d %03b, got key %0b %02h ptr %0b %0d %0d %03b"},
                                 n_checked, want.key_valid, want.key_byte, want.ptr_valid,
                                 want.ptr_x, want.ptr_y, want.ptr_buttons,
                                 got.key_valid, got.key_byte, got.ptr_valid,
                                 got.ptr_x, got.ptr_y, got.ptr_buttons);
                    end
                    n_bad++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads on empty queues, ctrl and special keys, text, pointer limits
        push_plain(kpq_pkg::CMD_READ_KEY);
        push_plain(kpq_pkg::CMD_READ_POINTER);
        push_key(kpq_pkg::CHAR_LOWER_A, kpq_pkg::SPECIAL_NONE, 1'b1);
        push_key(kpq_pkg::CHAR_LOWER_Z, kpq_pkg::SPECIAL_NONE, 1'b1);
        push_key(8'h35, kpq_pkg::SPECIAL_NONE, 1'b1);
        push_key(kpq_pkg::CHAR_LOWER_A, kpq_pkg::SPECIAL_UP, 1'b1);
        push_key(8'($urandom), kpq_pkg::SPECIAL_UP, 1'b0);
        push_key(8'($urandom), kpq_pkg::SPECIAL_LEFT, 1'b0);
        push_key(8'($urandom), kpq_pkg::SPECIAL_KP_ENTER, 1'b0);
        push_key(kpq_pkg::CHAR_CR, SPECIAL_UNKNOWN_LO, 1'b0);
        push_key(kpq_pkg::CHAR_TAB, SPECIAL_UNKNOWN_HI, 1'b0);
        push_key(kpq_pkg::CHAR_CR, kpq_pkg::SPECIAL_NONE, 1'b0);
        push_key(kpq_pkg::CHAR_BS, kpq_pkg::SPECIAL_NONE, 1'b0);
        push_key(kpq_pkg::CHAR_ESC, kpq_pkg::SPECIAL_NONE, 1'b0);
        push_key(kpq_pkg::CHAR_TAB, kpq_pkg::SPECIAL_NONE, 1'b0);
        push_key(8'h71, kpq_pkg::SPECIAL_NONE, 1'b0);
        push_text(8'h00);
        push_text(8'hff);
        push_plain(kpq_pkg::CMD_READ_KEY);
        push_ptr(kpq_pkg::CMD_MOVE, -16'sd32768, 16'sd32767, BTN_LEFT);
        push_plain(kpq_pkg::CMD_READ_POINTER);
        push_ptr(kpq_pkg::CMD_BUTTON_DOWN, 16'sd32767, -16'sd1, BTN_LEFT);
        push_ptr(kpq_pkg::CMD_BUTTON_DOWN, 16'sd100, 16'sd200, BTN_OTHER);
        push_ptr(kpq_pkg::CMD_BUTTON_UP, 16'sd5, 16'sd5, BTN_LEFT);
        push_plain(kpq_pkg::CMD_RESERVED);
        push_plain(kpq_pkg::CMD_READ_POINTER);
        push_plain(kpq_pkg::CMD_READ_KEY);
        wait_quiet();

        set_screen(13'd1, 13'd4096);
        queue_mix(450, 3, 2, 2, 2, 3, 2, 1);
        wait_quiet();

        // overfill the key ring, then read from it
        set_screen(13'd0, 13'h1fff);
        queue_mix(300, 5, 4, 0, 0, 0, 0, 0);
        queue_mix(120, 1, 0, 0, 0, 8, 0, 0);
        wait_quiet();

        // overfill the edge ring, then drain it
        set_screen(13'd4096, 13'd4097);
        queue_mix(90, 0, 0, 1, 8, 0, 1, 0);
        queue_mix(40, 0, 0, 1, 1, 0, 6, 0);
        wait_quiet();

        // long receiver hold while reads keep coming
        set_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
        queue_mix(200, 1, 1, 1, 1, 3, 3, 0);
        hold_ask = ~hold_ask;
        wait_quiet();

        set_screen(13'h1fff, 13'd1);
        queue_mix(400, 3, 2, 2, 2, 3, 2, 1);
        wait_quiet();

        set_screen(kpq_pkg::WIDTH_RESET, kpq_pkg::HEIGHT_RESET);
        idle_on = 1'b0;
        queue_mix(250, 3, 2, 2, 2, 3, 2, 1);
        wait_quiet();

        n_bad += reads_due.size();
        $display("covered %0d input transactions over %0d screen settings, %0d reads checked",
                 n_sent, n_settings, n_checked);
        $display("mismatches: %0d", n_bad);
        if (n_bad == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/kpq_pkg.sv
rtl/kpq_ram.sv
rtl/keyboard_pointer_event_queue_core.sv
dv/keyboard_pointer_event_queue_core_tb.sv
